### design/ubxtf_pkg.sv
// Shared constants and types of the UBX time frame parser.
`default_nettype none

package ubxtf_pkg;

  // Frame header bytes ahead of the length field
  localparam logic [7:0] UBX_SYNC1    = 8'hB5;
  localparam logic [7:0] UBX_SYNC2    = 8'h62;
  localparam logic [7:0] UBX_CLASS    = 8'h01;
  localparam logic [7:0] UBX_ID       = 8'h06;
  localparam int         UBX_HDR_LEN  = 6;

  // Payload offsets of the captured fields
  localparam int         TOW_OFF      = 0;
  localparam int         WEEK_OFF     = 8;

  // Result field widths
  localparam int         WEEK_W       = 16;
  localparam int         SECS_W       = 23;
  localparam int         TOW_W        = 32;

  // Divide by 1000: floor(x * RECIP / 2^38) is exact for every 32-bit x
  localparam int         RECIP_W      = 29;
  localparam logic [RECIP_W-1:0] MS_RECIP = 29'h10624DD3;
  localparam int         RECIP_SHIFT  = 38;
  localparam int         PROD_W       = TOW_W + RECIP_W;

  // Frame status codes
  localparam logic       STATUS_GOOD  = 1'b0;
  localparam logic       STATUS_BAD   = 1'b1;

  typedef logic [7:0]        byte_t;
  typedef logic [WEEK_W-1:0] week_t;
  typedef logic [SECS_W-1:0] secs_t;

endpackage

`default_nettype wire

### design/ubxtf_if.sv
// Valid/ready channels for received bytes and parsed frame results.
`default_nettype none

interface ubxtf_in_if;
  import ubxtf_pkg::*;
  logic  valid;
  logic  ready;
  byte_t rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface ubxtf_out_if;
  import ubxtf_pkg::*;
  logic  valid;
  logic  ready;
  logic  frame_status;
  week_t gps_week;
  secs_t week_seconds;

  modport source (output valid, output frame_status, output gps_week,
                  output week_seconds, input ready);
  modport sink   (input valid, input frame_status, input gps_week,
                  input week_seconds, output ready);
endinterface

`default_nettype wire

### design/ubx_time_frame_parser_top.sv
// UBX NAV-SOL time frame parser: header hunt, Fletcher check, week and seconds.
// Throughput: one byte per clock; in_if.ready drops only when the second
//   checksum byte arrives while the previous result still sits unread.
// Latency: the result is valid the cycle after the second checksum byte.
// The divide by 1000 is a registered reciprocal multiply, settled long before
//   the frame ends. Synchronous active-low reset returns the parser to the
//   header hunt with cleared sums and an empty result register.
`default_nettype none

module ubx_time_frame_parser_top #(
  parameter int PAYLOAD_LEN = 52
) (
  input  wire logic    clk,
  input  wire logic    rst_n,
  ubxtf_in_if.sink     in_if,
  ubxtf_out_if.source  out_if
);
  import ubxtf_pkg::*;

  localparam int POS_CHK_A_I = UBX_HDR_LEN + PAYLOAD_LEN;
  localparam int POS_W       = $clog2(POS_CHK_A_I + 2);

  localparam logic [POS_W-1:0] POS_SUM0  = POS_W'(2);
  localparam logic [POS_W-1:0] POS_HDR   = POS_W'(UBX_HDR_LEN);
  localparam logic [POS_W-1:0] POS_TOW0  = POS_W'(UBX_HDR_LEN + TOW_OFF);
  localparam logic [POS_W-1:0] POS_TOW1  = POS_W'(UBX_HDR_LEN + TOW_OFF + 1);
  localparam logic [POS_W-1:0] POS_TOW2  = POS_W'(UBX_HDR_LEN + TOW_OFF + 2);
  localparam logic [POS_W-1:0] POS_TOW3  = POS_W'(UBX_HDR_LEN + TOW_OFF + 3);
  localparam logic [POS_W-1:0] POS_WK0   = POS_W'(UBX_HDR_LEN + WEEK_OFF);
  localparam logic [POS_W-1:0] POS_WK1   = POS_W'(UBX_HDR_LEN + WEEK_OFF + 1);
  localparam logic [POS_W-1:0] POS_CHK_A = POS_W'(POS_CHK_A_I);
  localparam logic [POS_W-1:0] POS_CHK_B = POS_W'(POS_CHK_A_I + 1);

  localparam logic [15:0] LEN16 = 16'(PAYLOAD_LEN);

  logic [POS_W-1:0]  pos_r, pos_nxt;
  byte_t             sum_a_r, sum_a_nxt;
  byte_t             sum_b_r, sum_b_nxt;
  byte_t             chk_a_r, chk_a_nxt;
  logic [TOW_W-1:0]  tow_r, tow_nxt;
  week_t             week_r, week_nxt;
  secs_t             secs_r;

  logic              out_valid_r, out_valid_nxt;
  logic              status_r, status_nxt;
  week_t             out_week_r, out_week_nxt;
  secs_t             out_secs_r, out_secs_nxt;

  logic              in_fire;
  byte_t             rx;
  byte_t             hdr_exp;
  byte_t             sum_a_add;
  byte_t             sum_b_add;
  logic              res_fire;
  logic              chk_good;
  logic [PROD_W-1:0] tow_prod;

  assign rx      = in_if.rx_byte;
  // Stall only a result-producing byte while the result register is full and not being read
  assign in_if.ready = !((pos_r == POS_CHK_B) && out_valid_r && !out_if.ready);
  assign in_fire = in_if.valid && in_if.ready;

  // Expected header byte at each hunt position
  always_comb begin
    unique case (pos_r[2:0])
      3'd0:    hdr_exp = UBX_SYNC1;
      3'd1:    hdr_exp = UBX_SYNC2;
      3'd2:    hdr_exp = UBX_CLASS;
      3'd3:    hdr_exp = UBX_ID;
      3'd4:    hdr_exp = LEN16[7:0];
      default: hdr_exp = LEN16[15:8];
    endcase
  end

  // Fletcher step on the incoming byte
  assign sum_a_add = sum_a_r + rx;
  assign sum_b_add = sum_b_r + sum_a_add;
  assign chk_good  = (chk_a_r == sum_a_r) && (rx == sum_b_r);

  // Frame walk: hunt, sum, capture, check
  always_comb begin
    pos_nxt   = pos_r;
    sum_a_nxt = sum_a_r;
    sum_b_nxt = sum_b_r;
    chk_a_nxt = chk_a_r;
    tow_nxt   = tow_r;
    week_nxt  = week_r;
    res_fire  = 1'b0;
    if (in_fire) begin
      if (pos_r < POS_HDR) begin
        if (rx != hdr_exp) begin
          pos_nxt   = '0;
          sum_a_nxt = '0;
          sum_b_nxt = '0;
        end else begin
          if (pos_r >= POS_SUM0) begin
            sum_a_nxt = sum_a_add;
            sum_b_nxt = sum_b_add;
          end
          pos_nxt = pos_r + 1'b1;
        end
      end else if (pos_r < POS_CHK_A) begin
        sum_a_nxt = sum_a_add;
        sum_b_nxt = sum_b_add;
        if (pos_r == POS_TOW0) tow_nxt[7:0]    = rx;
        if (pos_r == POS_TOW1) tow_nxt[15:8]   = rx;
        if (pos_r == POS_TOW2) tow_nxt[23:16]  = rx;
        if (pos_r == POS_TOW3) tow_nxt[31:24]  = rx;
        if (pos_r == POS_WK0)  week_nxt[7:0]   = rx;
        if (pos_r == POS_WK1)  week_nxt[15:8]  = rx;
        pos_nxt = pos_r + 1'b1;
      end else if (pos_r == POS_CHK_A) begin
        chk_a_nxt = rx;
        pos_nxt   = pos_r + 1'b1;
      end else begin
        res_fire  = 1'b1;
        pos_nxt   = '0;
        sum_a_nxt = '0;
        sum_b_nxt = '0;
      end
    end
  end

  // Load a result or drop it once taken
  always_comb begin
    out_valid_nxt = out_valid_r;
    status_nxt    = status_r;
    out_week_nxt  = out_week_r;
    out_secs_nxt  = out_secs_r;
    if (res_fire) begin
      out_valid_nxt = 1'b1;
      status_nxt    = chk_good ? STATUS_GOOD : STATUS_BAD;
      out_week_nxt  = chk_good ? week_r : '0;
      out_secs_nxt  = chk_good ? secs_r : '0;
    end else if (out_if.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  // Reciprocal multiply for the millisecond-to-second divide
  assign tow_prod = PROD_W'(tow_r) * PROD_W'(MS_RECIP);

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r       <= '0;
      sum_a_r     <= '0;
      sum_b_r     <= '0;
      chk_a_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      pos_r       <= pos_nxt;
      sum_a_r     <= sum_a_nxt;
      sum_b_r     <= sum_b_nxt;
      chk_a_r     <= chk_a_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload captures and result fields
  always_ff @(posedge clk) begin
    tow_r      <= tow_nxt;
    week_r     <= week_nxt;
    secs_r     <= tow_prod[RECIP_SHIFT +: SECS_W];
    status_r   <= status_nxt;
    out_week_r <= out_week_nxt;
    out_secs_r <= out_secs_nxt;
  end

  assign out_if.valid        = out_valid_r;
  assign out_if.frame_status = status_r;
  assign out_if.gps_week     = out_week_r;
  assign out_if.week_seconds = out_secs_r;

  // Checks
  a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
    pos_r <= POS_CHK_B)
    else $error("frame position past second checksum byte");

  a_result_loads: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && (pos_r == POS_CHK_B)) |=> (out_valid_r && (pos_r == '0)))
    else $error("second checksum byte did not load a result and rehunt");

  a_bad_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (status_r == STATUS_BAD)) |->
      ((out_week_r == '0) && (out_secs_r == '0)))
    else $error("bad frame carries nonzero fields");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_if.ready) |-> !res_fire)
    else $error("pending result overwritten");

endmodule

`default_nettype wire
